/* src/jcs_pkg.sv */
// ----------------------------------------------------------------------------
// jcs_pkg : shared types and constants for the joystick calibrate/scale block
// Field widths, register indexes, modes, channel codes, sequencer states and
// the control structs that pass between the block's modules.
// ----------------------------------------------------------------------------
package jcs_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int BTN_W      = 4;
    localparam int RANGE_W    = 12;
    localparam int TRIM_W     = 11;
    localparam int RES_W      = 16;
    localparam int QUO_BITS   = 17;   // enough to tell 32768 from anything above

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = MODE_W + CHAN_W;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = CHAN_W;
    localparam int M_PAD_W    = M_TDATA_W - RES_W - 2;

    localparam logic [RANGE_W-1:0] THROTTLE_RANGE_RST = 12'd1000;
    localparam logic [RANGE_W-1:0] AXIS_RANGE_RST     = 12'd500;

    localparam logic signed [TRIM_W-1:0] TRIM_MAX = 11'sh3FF;
    localparam logic signed [TRIM_W-1:0] TRIM_MIN = 11'sh400;

    localparam logic signed [RES_W-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [RES_W-1:0] SAT_NEG = 16'sh8000;
    localparam logic [QUO_BITS-1:0] POS_LIMIT_MAG = 17'd32767;
    localparam logic [QUO_BITS-1:0] NEG_LIMIT_MAG = 17'd32768;

    localparam int BTN_PITCH_UP = 0;
    localparam int BTN_PITCH_DN = 1;
    localparam int BTN_ROLL_UP  = 2;
    localparam int BTN_ROLL_DN  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE     = 2'd0,
        MODE_CLR_MINMAX = 2'd1,
        MODE_CLR_MID    = 2'd2
    } mode_t;

    typedef enum logic [CHAN_W-1:0] {
        CH_THROTTLE = 2'd0,
        CH_ROLL     = 2'd1,
        CH_PITCH    = 2'd2,
        CH_YAW      = 2'd3
    } chan_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MINMAX_EN      = 2'd0,
        REG_MID_EN         = 2'd1,
        REG_THROTTLE_RANGE = 2'd2,
        REG_AXIS_RANGE     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_MUL,
        ST_DIV,
        ST_POST
    } state_t;

    // update request from the sequencer to the calibration store
    typedef struct packed {
        logic              upd;
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] chan;
        logic [BTN_W-1:0]  buttons;
        logic              minmax_en;
        logic              mid_en;
    } cal_cmd_t;

    typedef struct packed {
        logic                     calibrated;
        logic signed [TRIM_W-1:0] roll_trim;
        logic signed [TRIM_W-1:0] pitch_trim;
    } cal_stat_t;

endpackage

/* src/jcs_div.sv */
// ----------------------------------------------------------------------------
// jcs_div : serial restoring divider
// One quotient bit per cycle. The dividend's upper part is checked against
// the divisor at load, so a quotient too wide for QUO_BITS is flagged.
// ----------------------------------------------------------------------------
module jcs_div #(
    parameter int SAMPLE_BITS = jcs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [SAMPLE_BITS+jcs_pkg::RANGE_W-1:0]   dividend,
    input  logic [SAMPLE_BITS-1:0]                    divisor,
    output logic                                      done,
    output logic [jcs_pkg::QUO_BITS-1:0]              quotient,
    output logic                                      overflow
);
    localparam int PW    = SAMPLE_BITS + jcs_pkg::RANGE_W;
    localparam int QB    = jcs_pkg::QUO_BITS;
    localparam int CNT_W = $clog2(QB + 1);

    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [QB-1:0]          quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   ovf_reg, ovf_next;

    logic [SAMPLE_BITS-1:0] hi_ext;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   diff;
    logic                   ge;

    assign hi_ext  = SAMPLE_BITS'(dividend[PW-1:QB]);
    assign shifted = {rem_reg, quo_reg[QB-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = hi_ext;
            quo_next  = dividend[QB-1:0];
            dvs_next  = divisor;
            ovf_next  = hi_ext >= divisor;
            cnt_next  = CNT_W'(QB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            quo_next = {quo_reg[QB-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

/* src/jcs_cal_store.sv */
// ----------------------------------------------------------------------------
// jcs_cal_store : per-channel calibration store, trims and button latch
// Tracks min, max and midpoint per channel, the sticky calibrated flag, and
// steps the roll/pitch trims on button release.
// ----------------------------------------------------------------------------
module jcs_cal_store #(
    parameter int NUM_CHANNELS = jcs_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS  = jcs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  jcs_pkg::cal_cmd_t       cmd,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic [SAMPLE_BITS-1:0]  rd_min,
    output logic [SAMPLE_BITS-1:0]  rd_max,
    output logic [SAMPLE_BITS-1:0]  rd_mid,
    output jcs_pkg::cal_stat_t      stat
);
    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam logic signed [jcs_pkg::TRIM_W-1:0] TRIM_ONE = 11'sd1;

    logic [SAMPLE_BITS-1:0] min_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] min_next[NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] max_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] max_next[NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] mid_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] mid_next[NUM_CHANNELS];

    logic                              cal_reg, cal_next;
    logic signed [jcs_pkg::TRIM_W-1:0] roll_reg, roll_next;
    logic signed [jcs_pkg::TRIM_W-1:0] pitch_reg, pitch_next;
    logic [jcs_pkg::BTN_W-1:0]         latch_reg, latch_next;
    logic [jcs_pkg::BTN_W-1:0]         fire;
    logic [IDX_W-1:0]                  idx;

    function automatic logic signed [jcs_pkg::TRIM_W-1:0] trim_up(
        input logic signed [jcs_pkg::TRIM_W-1:0] t
    );
        return (t != jcs_pkg::TRIM_MAX) ? t + TRIM_ONE : t;
    endfunction

    function automatic logic signed [jcs_pkg::TRIM_W-1:0] trim_dn(
        input logic signed [jcs_pkg::TRIM_W-1:0] t
    );
        return (t != jcs_pkg::TRIM_MIN) ? t - TRIM_ONE : t;
    endfunction

    assign idx  = IDX_W'(cmd.chan);
    assign fire = latch_reg & ~cmd.buttons;

    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        mid_next   = mid_reg;
        cal_next   = cal_reg;
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        latch_next = latch_reg;
        if (cmd.upd) begin
            unique case (cmd.mode)
                jcs_pkg::MODE_SAMPLE: begin
                    if (cmd.minmax_en) begin
                        if (max_reg[idx] < sample) max_next[idx] = sample;
                        if (min_reg[idx] > sample) min_next[idx] = sample;
                    end
                    if (cmd.mid_en) mid_next[idx] = sample;
                    if (mid_next[0] != '0 && max_next[0] != '0) cal_next = 1'b1;
                    // steps applied in order: up then down, each saturating
                    if (fire[jcs_pkg::BTN_PITCH_UP]) pitch_next = trim_up(pitch_next);
                    if (fire[jcs_pkg::BTN_PITCH_DN]) pitch_next = trim_dn(pitch_next);
                    if (fire[jcs_pkg::BTN_ROLL_UP])  roll_next  = trim_up(roll_next);
                    if (fire[jcs_pkg::BTN_ROLL_DN])  roll_next  = trim_dn(roll_next);
                    latch_next = cmd.buttons;
                end
                jcs_pkg::MODE_CLR_MINMAX: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        min_next[i] = '1;
                        max_next[i] = '0;
                    end
                end
                jcs_pkg::MODE_CLR_MID: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) mid_next[i] = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
                mid_reg[i] <= '0;
            end
            cal_reg   <= 1'b0;
            roll_reg  <= '0;
            pitch_reg <= '0;
            latch_reg <= '0;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            mid_reg   <= mid_next;
            cal_reg   <= cal_next;
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            latch_reg <= latch_next;
        end
    end

    assign rd_min          = min_reg[idx];
    assign rd_max          = max_reg[idx];
    assign rd_mid          = mid_reg[idx];
    assign stat.calibrated = cal_reg;
    assign stat.roll_trim  = roll_reg;
    assign stat.pitch_trim = pitch_reg;

endmodule

/* src/joystick_calibrate_and_scale.sv */
// ----------------------------------------------------------------------------
// joystick_calibrate_and_scale : joystick axis calibration and scaling
// Sequence: an accepted item steps through ST_CAL, ST_MUL, ST_DIV and ST_POST;
//   reset modes and uncalibrated or zero-span samples skip ST_DIV.
// Flow: one item at a time, a new one only in ST_IDLE; the 17-step serial
//   divider takes longest. A waiting result does not block acceptance of the next item.
// Reset: aresetn (sync, low) resets the calibration store, trims and control registers.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_scale #(
    parameter int NUM_CHANNELS = jcs_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS  = jcs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [jcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [jcs_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // sample[15:0], buttons_pressed[19:16]
    input  logic [jcs_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // mode[1:0], channel[3:2]
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [jcs_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // scaled_value[15:0], divide_by_zero[16], cal_done[17]
    output logic [jcs_pkg::M_TUSER_W-1:0]     m_axis_tuser   // out_channel[1:0]
);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = SAMPLE_BITS + jcs_pkg::RANGE_W;
    localparam int QB = jcs_pkg::QUO_BITS;
    localparam int RW = jcs_pkg::RES_W;

    jcs_pkg::state_t state_reg, state_next;

    // configuration registers
    logic                        minmax_en_reg, minmax_en_next;
    logic                        mid_en_reg, mid_en_next;
    logic [jcs_pkg::RANGE_W-1:0] thr_range_reg, thr_range_next;
    logic [jcs_pkg::RANGE_W-1:0] axis_range_reg, axis_range_next;

    // item under work
    logic [jcs_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [jcs_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic [SB-1:0]              smp_reg, smp_next;
    logic [jcs_pkg::BTN_W-1:0]  btn_reg, btn_next;
    logic [PW-1:0]              prod_reg, prod_next;
    logic [SB-1:0]              dmag_reg, dmag_next;
    logic                       neg_reg, neg_next;
    logic signed [RW-1:0]       res_reg, res_next;
    logic                       dz_reg, dz_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [jcs_pkg::CHAN_W-1:0] out_chan_reg, out_chan_next;
    logic signed [RW-1:0]       out_val_reg, out_val_next;
    logic                       out_dz_reg, out_dz_next;
    logic                       out_done_reg, out_done_next;

    jcs_pkg::cal_cmd_t  cmd;
    jcs_pkg::cal_stat_t stat;
    logic [SB-1:0]      rd_min, rd_max, rd_mid;

    logic          div_start, div_done, div_ovf;
    logic [QB-1:0] div_q;

    // scaling terms
    logic signed [SB:0]           sv, mn_s, mx_s, md_s, num, den, num_abs, den_abs;
    logic                         above_mid;
    logic [jcs_pkg::RANGE_W-1:0]  scale;
    logic [PW-1:0]                prod;
    logic signed [RW-1:0]         sat_val;

    // trim and clamp terms
    logic signed [RW:0]           trim_ext, sum, sum_abs, lim_ext, clamped, negated;
    logic signed [jcs_pkg::TRIM_W-1:0] trim_sel;
    logic                         use_trim;
    logic signed [RW-1:0]         post_val;
    logic                         out_load;

    jcs_cal_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (smp_reg),
        .rd_min  (rd_min),
        .rd_max  (rd_max),
        .rd_mid  (rd_mid),
        .stat    (stat)
    );

    jcs_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dmag_reg),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    assign cmd.upd       = (state_reg == jcs_pkg::ST_CAL);
    assign cmd.mode      = mode_reg;
    assign cmd.chan      = chan_reg;
    assign cmd.buttons   = btn_reg;
    assign cmd.minmax_en = minmax_en_reg;
    assign cmd.mid_en    = mid_en_reg;

    // span and numerator from the freshly updated store
    always_comb begin
        sv        = $signed({1'b0, smp_reg});
        mn_s      = $signed({1'b0, rd_min});
        mx_s      = $signed({1'b0, rd_max});
        md_s      = $signed({1'b0, rd_mid});
        above_mid = sv > md_s;
        if (chan_reg == jcs_pkg::CH_THROTTLE) begin
            num   = sv - mn_s;
            den   = mx_s - mn_s;
            scale = thr_range_reg;
        end else begin
            num   = sv - md_s;
            den   = above_mid ? (mx_s - md_s) : (md_s - mn_s);
            scale = axis_range_reg;
        end
        num_abs = num[SB] ? -num : num;
        den_abs = den[SB] ? -den : den;
    end

    assign prod = PW'(num_abs[SB-1:0]) * PW'(scale);

    // saturate the quotient magnitude to a signed 16-bit result
    always_comb begin
        if (neg_reg) begin
            if (div_ovf || div_q > jcs_pkg::NEG_LIMIT_MAG) sat_val = jcs_pkg::SAT_NEG;
            else                                           sat_val = RW'(-div_q);
        end else begin
            if (div_ovf || div_q > jcs_pkg::POS_LIMIT_MAG) sat_val = jcs_pkg::SAT_POS;
            else                                           sat_val = RW'(div_q);
        end
    end

    // roll and pitch in sample mode: add trim, clamp to +/- axis range, negate
    always_comb begin
        use_trim = (mode_reg == jcs_pkg::MODE_SAMPLE) &&
                   (chan_reg == jcs_pkg::CH_ROLL || chan_reg == jcs_pkg::CH_PITCH);
        trim_sel = (chan_reg == jcs_pkg::CH_ROLL) ? stat.roll_trim : stat.pitch_trim;
        trim_ext = (RW+1)'(trim_sel);
        sum      = trim_ext + (RW+1)'(res_reg);
        sum_abs  = sum[RW] ? -sum : sum;
        lim_ext  = $signed({{(RW+1-jcs_pkg::RANGE_W){1'b0}}, axis_range_reg});
        if (sum_abs > lim_ext) clamped = sum[RW] ? -lim_ext : lim_ext;
        else                   clamped = sum;
        negated  = -clamped;
        post_val = use_trim ? negated[RW-1:0] : res_reg;
    end

    assign out_load = (state_reg == jcs_pkg::ST_POST) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next      = state_reg;
        minmax_en_next  = minmax_en_reg;
        mid_en_next     = mid_en_reg;
        thr_range_next  = thr_range_reg;
        axis_range_next = axis_range_reg;
        mode_next       = mode_reg;
        chan_next       = chan_reg;
        smp_next        = smp_reg;
        btn_next        = btn_reg;
        prod_next       = prod_reg;
        dmag_next       = dmag_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        dz_next         = dz_reg;
        m_valid_next    = m_valid_reg;
        out_chan_next   = out_chan_reg;
        out_val_next    = out_val_reg;
        out_dz_next     = out_dz_reg;
        out_done_next   = out_done_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                jcs_pkg::REG_MINMAX_EN:      minmax_en_next  = cfg_wdata[0];
                jcs_pkg::REG_MID_EN:         mid_en_next     = cfg_wdata[0];
                jcs_pkg::REG_THROTTLE_RANGE: thr_range_next  = cfg_wdata;
                jcs_pkg::REG_AXIS_RANGE:     axis_range_next = cfg_wdata;
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_axis_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            jcs_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    mode_next  = s_axis_tuser[jcs_pkg::MODE_W-1:0];
                    chan_next  = s_axis_tuser[jcs_pkg::S_TUSER_W-1:jcs_pkg::MODE_W];
                    smp_next   = s_axis_tdata[SB-1:0];
                    btn_next   = s_axis_tdata[jcs_pkg::SAMPLE_W +: jcs_pkg::BTN_W];
                    state_next = jcs_pkg::ST_CAL;
                end
            end
            jcs_pkg::ST_CAL: begin
                state_next = jcs_pkg::ST_MUL;
            end
            jcs_pkg::ST_MUL: begin
                res_next = '0;
                dz_next  = 1'b0;
                if (mode_reg != jcs_pkg::MODE_SAMPLE || !stat.calibrated) begin
                    state_next = jcs_pkg::ST_POST;
                end else if (den == '0) begin
                    dz_next    = 1'b1;
                    state_next = jcs_pkg::ST_POST;
                end else begin
                    prod_next  = prod;
                    dmag_next  = den_abs[SB-1:0];
                    neg_next   = num[SB] ^ den[SB];
                    state_next = jcs_pkg::ST_DIV;
                end
            end
            jcs_pkg::ST_DIV: begin
                // the divider loads in the cycle after the product is registered
                if (div_done) begin
                    res_next   = sat_val;
                    state_next = jcs_pkg::ST_POST;
                end
            end
            jcs_pkg::ST_POST: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    out_chan_next = chan_reg;
                    out_val_next  = post_val;
                    out_dz_next   = dz_reg;
                    out_done_next = stat.calibrated;
                    state_next    = jcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jcs_pkg::ST_IDLE;
            end
        endcase
    end

    // start pulse, registered on entering the divide state
    logic div_pend_reg, div_pend_next;
    assign div_pend_next = (state_reg == jcs_pkg::ST_MUL) && (state_next == jcs_pkg::ST_DIV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= jcs_pkg::ST_IDLE;
            minmax_en_reg  <= 1'b0;
            mid_en_reg     <= 1'b0;
            thr_range_reg  <= jcs_pkg::THROTTLE_RANGE_RST;
            axis_range_reg <= jcs_pkg::AXIS_RANGE_RST;
            m_valid_reg    <= 1'b0;
            div_pend_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            minmax_en_reg  <= minmax_en_next;
            mid_en_reg     <= mid_en_next;
            thr_range_reg  <= thr_range_next;
            axis_range_reg <= axis_range_next;
            m_valid_reg    <= m_valid_next;
            div_pend_reg   <= div_pend_next;
        end
        mode_reg     <= mode_next;
        chan_reg     <= chan_next;
        smp_reg      <= smp_next;
        btn_reg      <= btn_next;
        prod_reg     <= prod_next;
        dmag_reg     <= dmag_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        dz_reg       <= dz_next;
        out_chan_reg <= out_chan_next;
        out_val_reg  <= out_val_next;
        out_dz_reg   <= out_dz_next;
        out_done_reg <= out_done_next;
    end

    always_comb begin
        div_start = div_pend_reg;
    end

    assign s_axis_tready = (state_reg == jcs_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{jcs_pkg::M_PAD_W{1'b0}}, out_done_reg, out_dz_reg, out_val_reg};
    assign m_axis_tuser  = out_chan_reg;

endmodule

/* src/jcs_checker.sv */
// ----------------------------------------------------------------------------
// jcs_checker : port-level checks for joystick_calibrate_and_scale
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module jcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [jcs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    localparam int DZ_BIT   = jcs_pkg::RES_W;
    localparam int DONE_BIT = jcs_pkg::RES_W + 1;

    logic seen_done_reg, seen_done_next;

    assign seen_done_next = seen_done_reg || (m_axis_tvalid && m_axis_tdata[DONE_BIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_done_reg <= 1'b0;
        end else begin
            seen_done_reg <= seen_done_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // one item at a time: no acceptance directly after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item was in work");

    // a new result only appears from the busy sequencer
    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in work");

    // a zero span is only reported once calibrated
    a_dz_needs_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[DZ_BIT] |-> m_axis_tdata[DONE_BIT])
        else $error("divide_by_zero flagged before calibration");

    // calibration done is sticky until reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && seen_done_reg |-> m_axis_tdata[DONE_BIT])
        else $error("cal_done dropped after being set");

endmodule

bind joystick_calibrate_and_scale jcs_checker u_jcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/tb_joystick_calibrate_and_scale.sv */
// ----------------------------------------------------------------------------
// tb_joystick_calibrate_and_scale : self-checking bench for the joystick block
// Drives sample and reset items through the input stream and checks every
// result item against an in-bench predictor of the calibration store, trims
// and scaling, or a directed row's typed expectation. A short directed table is
// followed by random items under six register settings and a short trim sweep both ways.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_joystick_calibrate_and_scale;

    import jcs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int N_CH           = DEF_NUM_CHANNELS;
    localparam int SETTLE_CYCLES  = 25;     // longest division plus margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 125;
    localparam int TRIM_SWEEP     = 20;     // releases per direction
    localparam logic [BTN_W-1:0] SWEEP_OUT  = (4'b1 << BTN_PITCH_UP) | (4'b1 << BTN_ROLL_DN);
    localparam logic [BTN_W-1:0] SWEEP_BACK = (4'b1 << BTN_PITCH_DN) | (4'b1 << BTN_ROLL_UP);

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        chan_t               chan;
        logic [SAMPLE_W-1:0] sample;
        logic [BTN_W-1:0]    buttons;
    } stick_in_t;

    typedef struct packed {
        chan_t                   chan;
        logic signed [RES_W-1:0] val;
        logic                    dz;
        logic                    done;
    } stick_res_t;

    typedef struct packed {
        logic                is_set;
        logic                mm;
        logic                md;
        logic [RANGE_W-1:0]  thr;
        logic [RANGE_W-1:0]  ax;
        stick_in_t           it;
        logic                typed;
        stick_res_t          exp;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // sample[15:0], buttons_pressed[19:16]
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // mode[1:0], channel[3:2]

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // scaled_value[15:0], divide_by_zero[16], cal_done[17]
    logic [M_TUSER_W-1:0] m_axis_tuser;        // out_channel[1:0]

    // typed expectation travelling alongside the item being offered
    logic       typed_on  = 1'b0;
    stick_res_t typed_res = '0;

    // predictor state and register copies
    logic [SAMPLE_W-1:0] lo_seen [N_CH];
    logic [SAMPLE_W-1:0] hi_seen [N_CH];
    logic [SAMPLE_W-1:0] centre  [N_CH];
    logic                cal_ok;
    int                  roll_trim, pitch_trim;
    logic [BTN_W-1:0]    held_btn;
    logic                minmax_on, mid_on;
    logic [RANGE_W-1:0]  thr_span, axis_span;

    stick_res_t want_q [$];
    stick_in_t  acc_item;
    stick_res_t want, got;

    int send_gap   = 0;
    int recv_stall = 0;
    int n_in       = 0;
    int n_out      = 0;
    int n_dz       = 0;
    int n_rand     = 0;
    int n_bad      = 0;
    int quiet      = 0;

    joystick_calibrate_and_scale uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    function automatic int trim_nudge(input int t, input logic up);
        if (up) return (t < TRIM_MAX) ? t + 1 : t;
        return (t > TRIM_MIN) ? t - 1 : t;
    endfunction

    // trim, clamp to the axis span, then invert
    function automatic int trim_clamp(input int v, input int t);
        int lim, sum, mag;
        lim = axis_span;
        sum = t + v;
        mag = (sum < 0) ? -sum : sum;
        if (mag > lim) v = (sum > 0) ? lim : -lim;
        else v = sum;
        return -v;
    endfunction

    function automatic stick_res_t scale_stick(input stick_in_t it);
        stick_res_t r;
        logic [BTN_W-1:0] fire;
        longint sv, mn, mx, md, num, sc, den, q;
        int res;
        r.chan = it.chan;
        r.dz   = 1'b0;
        res    = 0;
        if (it.mode == MODE_CLR_MINMAX) begin
            for (int i = 0; i < N_CH; i++) begin
                hi_seen[i] = '0;
                lo_seen[i] = '1;
            end
        end else if (it.mode == MODE_CLR_MID) begin
            for (int i = 0; i < N_CH; i++) centre[i] = '0;
        end else if (it.mode == MODE_SAMPLE) begin
            if (minmax_on) begin
                if (hi_seen[it.chan] < it.sample) hi_seen[it.chan] = it.sample;
                if (lo_seen[it.chan] > it.sample) lo_seen[it.chan] = it.sample;
            end
            if (mid_on) centre[it.chan] = it.sample;
            if (centre[CH_THROTTLE] != 0 && hi_seen[CH_THROTTLE] != 0) cal_ok = 1'b1;

            // a trim steps when its button is released
            fire = held_btn & ~it.buttons;
            if (fire[BTN_PITCH_UP]) pitch_trim = trim_nudge(pitch_trim, 1'b1);
            if (fire[BTN_PITCH_DN]) pitch_trim = trim_nudge(pitch_trim, 1'b0);
            if (fire[BTN_ROLL_UP])  roll_trim  = trim_nudge(roll_trim, 1'b1);
            if (fire[BTN_ROLL_DN])  roll_trim  = trim_nudge(roll_trim, 1'b0);
            held_btn = it.buttons;

            sv = it.sample;
            mn = lo_seen[it.chan];
            mx = hi_seen[it.chan];
            md = centre[it.chan];
            if (cal_ok) begin
                if (it.chan == CH_THROTTLE) begin
                    num = sv - mn;
                    sc  = thr_span;
                    den = mx - mn;
                end else if (sv > md) begin
                    num = sv - md;
                    sc  = axis_span;
                    den = mx - md;
                end else begin
                    num = sv - md;
                    sc  = axis_span;
                    den = md - mn;
                end
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    q = (num * sc) / den;
                    if (q > SAT_POS) q = SAT_POS;
                    else if (q < SAT_NEG) q = SAT_NEG;
                    res = int'(q);
                end
            end
            if (it.chan == CH_ROLL) res = trim_clamp(res, roll_trim);
            else if (it.chan == CH_PITCH) res = trim_clamp(res, pitch_trim);
        end
        r.val  = res[RES_W-1:0];
        r.done = cal_ok;
        return r;
    endfunction

    function automatic stick_in_t rand_stick();
        stick_in_t it;
        int pick;
        pick    = $urandom_range(0, 99);
        it.mode = MODE_SAMPLE;
        if (pick < 2) it.mode = MODE_CLR_MINMAX;
        else if (pick < 4) it.mode = MODE_CLR_MID;
        else if (pick < 6) it.mode = MODE_UNUSED;
        it.chan = chan_t'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0: it.sample = '0;
            1: it.sample = '1;
            2: it.sample = centre[it.chan] + 16'($urandom_range(0, 8)) - 16'd4;
            3: it.sample = lo_seen[it.chan] + 16'($urandom_range(0, 3)) - 16'd1;
            4: it.sample = hi_seen[it.chan] + 16'($urandom_range(0, 3)) - 16'd2;
            default: it.sample = 16'($urandom());
        endcase
        it.buttons = $urandom_range(0, 1) ? 4'd0 : 4'($urandom());
        return it;
    endfunction

    function automatic dir_row_t row_item(input logic [MODE_W-1:0] mode, input chan_t ch,
                                          input logic [SAMPLE_W-1:0] smp,
                                          input logic [BTN_W-1:0] btn);
        dir_row_t r;
        r = '0;
        r.it.mode    = mode;
        r.it.chan    = ch;
        r.it.sample  = smp;
        r.it.buttons = btn;
        return r;
    endfunction

    function automatic dir_row_t row_chk(input logic [MODE_W-1:0] mode, input chan_t ch,
                                         input logic [SAMPLE_W-1:0] smp,
                                         input logic [BTN_W-1:0] btn,
                                         input int v, input logic dz, input logic done);
        dir_row_t r;
        r          = row_item(mode, ch, smp, btn);
        r.typed    = 1'b1;
        r.exp.chan = ch;
        r.exp.val  = v[RES_W-1:0];
        r.exp.dz   = dz;
        r.exp.done = done;
        return r;
    endfunction

    function automatic dir_row_t row_set(input logic mm, input logic md,
                                         input logic [RANGE_W-1:0] thr,
                                         input logic [RANGE_W-1:0] ax);
        dir_row_t r;
        r        = '0;
        r.is_set = 1'b1;
        r.mm     = mm;
        r.md     = md;
        r.thr    = thr;
        r.ax     = ax;
        return r;
    endfunction

    task automatic drive_stick(input stick_in_t it, input logic typed, input stick_res_t exp);
        while ($urandom_range(0, 99) < send_gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W - BTN_W){1'b0}}, it.buttons, it.sample};
        s_axis_tuser  <= {it.chan, it.mode};
        typed_on      <= typed;
        typed_res     <= exp;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge aclk);
    endtask

    // waits for every result, lets the divider settle, then writes all registers
    task automatic load_regs(input logic mm, input logic md,
                             input logic [RANGE_W-1:0] thr, input logic [RANGE_W-1:0] ax);
        s_axis_tvalid <= 1'b0;
        while (want_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MINMAX_EN;
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom()), mm};
        @(negedge aclk);
        cfg_addr  <= REG_MID_EN;
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom()), md};
        @(negedge aclk);
        cfg_addr  <= REG_THROTTLE_RANGE;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_addr  <= REG_AXIS_RANGE;
        cfg_wdata <= ax;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        minmax_on = mm;
        mid_on    = md;
        thr_span  = thr;
        axis_span = ax;
    endtask

    // scoreboard: predict on input handshake, compare on output handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet = quiet + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                acc_item.mode    = s_axis_tuser[MODE_W-1:0];
                acc_item.chan    = chan_t'(s_axis_tuser[MODE_W +: CHAN_W]);
                acc_item.sample  = s_axis_tdata[SAMPLE_W-1:0];
                acc_item.buttons = s_axis_tdata[SAMPLE_W +: BTN_W];
                want = scale_stick(acc_item);
                want_q.push_back(typed_on ? typed_res : want);
                n_in  <= n_in + 1;
                quiet = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet      = 0;
                n_out      <= n_out + 1;
                got.chan   = chan_t'(m_axis_tuser[CHAN_W-1:0]);
                got.val    = m_axis_tdata[RES_W-1:0];
                got.dz     = m_axis_tdata[RES_W];
                got.done   = m_axis_tdata[RES_W+1];
                if (got.dz) n_dz <= n_dz + 1;
                if (want_q.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("ERROR: unexpected result ch=%0d val=%0d dz=%0b done=%0b",
                                 got.chan, got.val, got.dz, got.done);
                end else begin
                    want = want_q.pop_front();
                    if (got.chan !== want.chan || got.val !== want.val ||
                        got.dz !== want.dz || got.done !== want.done) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10) begin
                            $display("ERROR: result %0d exp ch=%0d val=%0d dz=%0b done=%0b",
                                     n_out, want.chan, want.val, want.dz, want.done);
                            $display("       got ch=%0d val=%0d dz=%0b done=%0b",
                                     got.chan, got.val, got.dz, got.done);
                        end
                    end
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_joystick_calibrate_and_scale NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        dir_row_t  rows [$];
        stick_in_t it;
        stick_res_t none;

        none = '0;
        for (int i = 0; i < N_CH; i++) begin
            lo_seen[i] = '1;
            hi_seen[i] = '0;
            centre[i]  = '0;
        end
        cal_ok     = 1'b0;
        roll_trim  = 0;
        pitch_trim = 0;
        held_btn   = '0;
        minmax_on  = 1'b0;
        mid_on     = 1'b0;
        thr_span   = THROTTLE_RANGE_RST;
        axis_span  = AXIS_RANGE_RST;

        // reset-time registers, not yet calibrated: roll and pitch show only -trim
        rows.push_back(row_chk(MODE_SAMPLE, CH_THROTTLE, 16'h0000, 4'b0000, 0, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_ROLL, 16'hFFFF, 4'b1111, 0, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_PITCH, 16'h5A5A, 4'b0000, 0, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_ROLL, 16'hA5A5, 4'b0100, 0, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_ROLL, 16'h0001, 4'b0000, -1, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_PITCH, 16'h8000, 4'b0010, 0, 0, 0));
        // unused mode must not latch the buttons
        rows.push_back(row_chk(MODE_UNUSED, CH_YAW, 16'hFFFF, 4'b1111, 0, 0, 0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_PITCH, 16'h7FFF, 4'b1000, 1, 0, 0));
        rows.push_back(row_chk(MODE_CLR_MINMAX, CH_PITCH, 16'hFFFF, 4'b0000, 0, 0, 0));
        rows.push_back(row_chk(MODE_CLR_MID, CH_ROLL, 16'h0000, 4'b0000, 0, 0, 0));
        rows.push_back(row_set(1'b1, 1'b1, 12'd4095, 12'd0));
        rows.push_back(row_chk(MODE_SAMPLE, CH_ROLL, 16'h1234, 4'b0000, 0, 0, 0));
        // first throttle sample calibrates with a zero span
        rows.push_back(row_chk(MODE_SAMPLE, CH_THROTTLE, 16'h8000, 4'b0000, 0, 1, 1));
        rows.push_back(row_set(1'b1, 1'b0, 12'd4095, 12'd4095));
        rows.push_back(row_item(MODE_SAMPLE, CH_THROTTLE, 16'h8001, 4'b0000));
        rows.push_back(row_item(MODE_SAMPLE, CH_THROTTLE, 16'hFFFF, 4'b0000));
        rows.push_back(row_item(MODE_SAMPLE, CH_YAW, 16'h0010, 4'b0000));
        rows.push_back(row_chk(MODE_SAMPLE, CH_YAW, 16'h0000, 4'b0000, 0, 1, 1));
        rows.push_back(row_item(MODE_CLR_MINMAX, CH_THROTTLE, 16'h0000, 4'b0000));
        rows.push_back(row_item(MODE_SAMPLE, CH_THROTTLE, 16'h0100, 4'b0000));
        rows.push_back(row_item(MODE_SAMPLE, CH_THROTTLE, 16'h0101, 4'b0000));
        rows.push_back(row_item(MODE_SAMPLE, CH_YAW, 16'h0200, 4'b0000));
        // one-count throttle span: quotients saturate both ways; yaw saturates upward too
        rows.push_back(row_set(1'b0, 1'b0, 12'd4095, 12'd4095));
        rows.push_back(row_chk(MODE_SAMPLE, CH_THROTTLE, 16'hFFFF, 4'b0000, 32767, 0, 1));
        rows.push_back(row_chk(MODE_SAMPLE, CH_THROTTLE, 16'h0000, 4'b0000, -32768, 0, 1));
        rows.push_back(row_chk(MODE_SAMPLE, CH_YAW, 16'hFFFF, 4'b0000, 32767, 0, 1));
        rows.push_back(row_item(MODE_SAMPLE, CH_PITCH, 16'hFFFF, 4'b1111));
        rows.push_back(row_item(MODE_SAMPLE, CH_ROLL, 16'h0000, 4'b0000));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_gap   = 37;
        recv_stall = 67;
        foreach (rows[i]) begin
            if (rows[i].is_set) load_regs(rows[i].mm, rows[i].md, rows[i].thr, rows[i].ax);
            else drive_stick(rows[i].it, rows[i].typed, rows[i].exp);
        end

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_gap   = 67;
                recv_stall = 37;
            end else if (p == 4) begin
                send_gap   = 0;
                recv_stall = 0;
            end
            case (p)
                0: load_regs(1'b1, 1'b1, 12'($urandom()), 12'($urandom()));
                1: load_regs(1'b0, 1'b0, 12'd4095, 12'd4095);
                2: load_regs(1'b1, 1'b0, 12'd0, 12'd0);
                3: load_regs(1'($urandom()), 1'($urandom()), 12'($urandom()), 12'($urandom()));
                4: load_regs(1'b0, 1'b0, 12'($urandom()), 12'($urandom_range(0, 700)));
                default: load_regs(1'b1, 1'b0, 12'($urandom()), 12'($urandom_range(0, 1200)));
            endcase
            repeat (PHASE_ITEMS) begin
                drive_stick(rand_stick(), 1'b0, none);
                n_rand++;
            end
        end

        // step pitch up and roll down, then back again
        load_regs(1'b0, 1'b0, 12'($urandom()), 12'd700);
        for (int k = 0; k < 4 * TRIM_SWEEP; k++) begin
            it      = rand_stick();
            it.mode = MODE_SAMPLE;
            if (k[0]) it.buttons = '0;
            else it.buttons = (k < 2 * TRIM_SWEEP) ? SWEEP_OUT : SWEEP_BACK;
            drive_stick(it, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (want_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES + 5) @(negedge aclk);

        $display("Covered %0d items: directed table, %0d random over six register settings,",
                 n_in, n_rand);
        $display("trim sweep both ways; %0d results checked, %0d divide-by-zero, %0d mismatches",
                 n_out, n_dz, n_bad);
        if (n_bad == 0) begin
            $display("tb_joystick_calibrate_and_scale OK");
        end else begin
            $display("tb_joystick_calibrate_and_scale NOT OK");
        end
        $finish;
    end

endmodule
